>>> rtl/core/ljpe_pkg.sv
package ljpe_pkg;

  localparam int unsigned DistW   = 24;
  localparam int unsigned SigW    = 24;
  localparam int unsigned EpsW    = 20;
  localparam int unsigned EnergyW = 40;
  localparam int unsigned TotalW  = 48;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned SlackW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  localparam logic [CfgIdxW-1:0] REG_CUTOFF   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SLACK    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DSCALE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REP_ONLY = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPECIAL  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CAV_EN   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CAV_SCL  = 3'd6;

  localparam logic [63:0] P_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [EnergyW-1:0] E_MAX = {1'b0, {(EnergyW-1){1'b1}}};
  localparam logic signed [EnergyW-1:0] E_MIN = {1'b1, {(EnergyW-1){1'b0}}};
  localparam logic signed [TotalW-1:0]  T_MAX = {1'b0, {(TotalW-1){1'b1}}};
  localparam logic signed [TotalW-1:0]  T_MIN = {1'b1, {(TotalW-1){1'b0}}};

  typedef struct packed {
    logic [DistW-1:0]  cutoff_distance;
    logic [SlackW-1:0] cutoff_slack;
    logic [ScaleW-1:0] dispersion_scale;
    logic              repulsion_only;
    logic              special_mode;
    logic              cavity_enable;
    logic [ScaleW-1:0] cavity_scale;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_CACHED,
    KIND_REJECT,
    KIND_COMPUTE
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [DistW-1:0]           r;
    logic [SigW-1:0]            mag;
    logic [EpsW-1:0]            abs_eps;
    logic                       eps_neg;
    logic                       attr;
    logic signed [EnergyW-1:0]  cached;
    logic                       last;
  } entry_t;

endpackage

>>> rtl/core/ljpe_front.sv
module ljpe_front (
  input  ljpe_pkg::cfg_t                       cfg,
  input  logic [ljpe_pkg::DistW-1:0]           pair_distance,
  input  logic signed [ljpe_pkg::SigW-1:0]     pair_sigma,
  input  logic signed [ljpe_pkg::EpsW-1:0]     pair_epsilon,
  input  logic                                 excluded,
  input  logic                                 frozen_pair,
  input  logic                                 attr_only,
  input  logic                                 recalculate,
  input  logic signed [ljpe_pkg::EnergyW-1:0]  cached_energy,
  input  logic                                 last_pair,
  output ljpe_pkg::entry_t                     entry
);

  logic [ljpe_pkg::SigW-1:0]    mag;
  logic [ljpe_pkg::EpsW-1:0]    abs_eps;
  logic [ljpe_pkg::DistW:0]     cut_lim;
  logic                         in_cut;
  logic [ljpe_pkg::DistW+13:0]  r_shift;
  logic [ljpe_pkg::DistW+15:0]  cav_lim;
  logic                         cav_hit;

  assign mag     = pair_sigma[ljpe_pkg::SigW-1] ? (~pair_sigma + 1'b1) : pair_sigma;
  assign abs_eps = pair_epsilon[ljpe_pkg::EpsW-1] ? (~pair_epsilon + 1'b1) : pair_epsilon;

  // r - slack < cutoff, rearranged so that no sign is needed.
  assign cut_lim = {1'b0, cfg.cutoff_distance} + {9'd0, cfg.cutoff_slack};
  assign in_cut  = {1'b0, pair_distance} < cut_lim;

  assign r_shift = {pair_distance, 14'd0};
  assign cav_lim = (ljpe_pkg::DistW+16)'(cfg.cavity_scale) * (ljpe_pkg::DistW+16)'(mag);
  assign cav_hit = {2'b00, r_shift} < cav_lim;

  always_comb begin
    entry.r       = pair_distance;
    entry.mag     = mag;
    entry.abs_eps = abs_eps;
    entry.eps_neg = pair_epsilon[ljpe_pkg::EpsW-1];
    entry.attr    = attr_only;
    entry.cached  = cached_energy;
    entry.last    = last_pair;
    if (!recalculate) begin
      entry.kind = ljpe_pkg::KIND_CACHED;
    end else if (in_cut && !excluded && !frozen_pair) begin
      entry.kind = (cfg.cavity_enable && cav_hit) ? ljpe_pkg::KIND_REJECT
                                                   : ljpe_pkg::KIND_COMPUTE;
    end else begin
      entry.kind = ljpe_pkg::KIND_ZERO;
    end
  end

endmodule

>>> rtl/core/ljpe_queue.sv
module ljpe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ljpe_pkg::entry_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output ljpe_pkg::entry_t  rd_data,
  output logic              empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ljpe_pkg::entry_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/ljpe_back.sv
module ljpe_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ljpe_pkg::cfg_t                       cfg,
  input  ljpe_pkg::entry_t                     q_data,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [ljpe_pkg::EnergyW-1:0]  out_pair_energy,
  output logic signed [ljpe_pkg::TotalW-1:0]   out_total_energy,
  output logic                                 out_rejected,
  output logic                                 out_sum_done
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_DONE} state_t;
  typedef enum logic [2:0] {OP_SQ, OP_S3, OP_S6, OP_S12, OP_SCL, OP_EPS} op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  ljpe_pkg::entry_t item_r, item_nxt;

  logic [63:0]  s_r, s_nxt, s6_r, s6_nxt, s12_r, s12_nxt;
  logic [47:0]  num_r, num_nxt, quo_r, quo_nxt;
  logic [23:0]  rem_r, rem_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [127:0] mcand_r, mcand_nxt, acc_r, acc_nxt;
  logic [63:0]  mplier_r, mplier_nxt;
  logic         neg_r, neg_nxt, rej_r, rej_nxt;
  logic signed [ljpe_pkg::EnergyW-1:0] e_r, e_nxt;
  logic signed [ljpe_pkg::TotalW-1:0]  total_r, total_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [ljpe_pkg::EnergyW-1:0] oe_r, oe_nxt;
  logic signed [ljpe_pkg::TotalW-1:0]  ot_r, ot_nxt;
  logic                                orej_r, orej_nxt, odone_r, odone_nxt;

  logic [24:0]  rem_t;
  logic         q_bit;
  logic [47:0]  quo_new;
  logic [63:0]  mres;
  logic [63:0]  t6;
  logic [63:0]  t12;
  logic [63:0]  diff;
  logic [63:0]  md;
  logic [63:0]  p_spec;
  logic [47:0]  p_eps;
  logic signed [ljpe_pkg::TotalW:0] sum_w;
  logic signed [ljpe_pkg::TotalW-1:0] sum_sat;

  // Saturating (a*b) >> sh on the finished product.
  function automatic logic [63:0] sat_shift(input logic [127:0] prod, input logic wide);
    logic [127:0] sh;
    begin
      sh = wide ? (prod >> 24) : (prod >> 14);
      if (prod[127:64] != '0) begin
        sat_shift = ljpe_pkg::P_MAX;
      end else if (sh > {64'd0, ljpe_pkg::P_MAX}) begin
        sat_shift = ljpe_pkg::P_MAX;
      end else begin
        sat_shift = sh[63:0];
      end
    end
  endfunction

  assign rem_t   = {rem_r, num_r[47]};
  assign q_bit   = rem_t >= {1'b0, item_r.r};
  assign quo_new = {quo_r[46:0], q_bit};
  assign mres    = sat_shift(acc_r, op_r != OP_SCL);
  assign t6      = cfg.repulsion_only ? 64'd0 : mres;
  assign t12     = item_r.attr ? 64'd0 : s12_r;
  assign diff    = t12 - t6;
  assign md      = diff[63] ? (~diff + 1'b1) : diff;
  assign p_spec  = mres >> 8;
  assign p_eps   = acc_r[61:14];

  assign sum_w   = (ljpe_pkg::TotalW+1)'(e_r) + (ljpe_pkg::TotalW+1)'(total_r);
  always_comb begin
    if (sum_w > (ljpe_pkg::TotalW+1)'(ljpe_pkg::T_MAX)) begin
      sum_sat = ljpe_pkg::T_MAX;
    end else if (sum_w < (ljpe_pkg::TotalW+1)'(ljpe_pkg::T_MIN)) begin
      sum_sat = ljpe_pkg::T_MIN;
    end else begin
      sum_sat = sum_w[ljpe_pkg::TotalW-1:0];
    end
  end

  assign q_pop            = (state_r == ST_IDLE) && !q_empty;
  assign out_empty        = !out_valid_r;
  assign out_pair_energy  = oe_r;
  assign out_total_energy = ot_r;
  assign out_rejected     = orej_r;
  assign out_sum_done     = odone_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    item_nxt      = item_r;
    s_nxt         = s_r;
    s6_nxt        = s6_r;
    s12_nxt       = s12_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    rej_nxt       = rej_r;
    e_nxt         = e_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_pop;
    oe_nxt        = oe_r;
    ot_nxt        = ot_r;
    orej_nxt      = orej_r;
    odone_nxt     = odone_r;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          item_nxt = q_data;
          rej_nxt  = 1'b0;
          state_nxt = ST_DONE;
          case (q_data.kind)
            ljpe_pkg::KIND_CACHED: e_nxt = q_data.cached;
            ljpe_pkg::KIND_REJECT: begin
              e_nxt   = ljpe_pkg::E_MAX;
              rej_nxt = 1'b1;
            end
            ljpe_pkg::KIND_COMPUTE: begin
              if (q_data.mag == '0 || q_data.r == '0) begin
                // Zero sigma gives s = 0; zero distance saturates s.
                s_nxt      = (q_data.mag == '0) ? 64'd0 : ljpe_pkg::P_MAX;
                mcand_nxt  = {64'd0, s_nxt};
                mplier_nxt = s_nxt;
                acc_nxt    = '0;
                op_nxt     = OP_SQ;
                state_nxt  = ST_MUL;
              end else begin
                num_nxt   = {q_data.mag, 24'd0};
                quo_nxt   = '0;
                rem_nxt   = '0;
                cnt_nxt   = 6'd47;
                state_nxt = ST_DIV;
              end
            end
            default: e_nxt = '0;
          endcase
        end
      end

      ST_DIV: begin
        rem_nxt = q_bit ? 24'(rem_t - {1'b0, item_r.r}) : rem_t[23:0];
        num_nxt = {num_r[46:0], 1'b0};
        quo_nxt = quo_new;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          s_nxt      = {16'd0, quo_new};
          mcand_nxt  = {80'd0, quo_new};
          mplier_nxt = {16'd0, quo_new};
          acc_nxt    = '0;
          op_nxt     = OP_SQ;
          state_nxt  = ST_MUL;
        end
      end

      ST_MUL: begin
        if (mplier_r != '0) begin
          if (mplier_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt  = {mcand_r[126:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[63:1]};
        end else begin
          acc_nxt = '0;
          case (op_r)
            OP_SQ: begin
              mcand_nxt  = {64'd0, mres};
              mplier_nxt = s_r;
              op_nxt     = OP_S3;
            end
            OP_S3: begin
              mcand_nxt  = {64'd0, mres};
              mplier_nxt = mres;
              op_nxt     = OP_S6;
            end
            OP_S6: begin
              s6_nxt     = mres;
              mcand_nxt  = {64'd0, mres};
              mplier_nxt = mres;
              op_nxt     = OP_S12;
            end
            OP_S12: begin
              s12_nxt = mres;
              if (cfg.special_mode) begin
                mcand_nxt  = {64'd0, mres};
                mplier_nxt = {48'd0, cfg.dispersion_scale};
                op_nxt     = OP_SCL;
              end else if (cfg.repulsion_only) begin
                // No dispersion term: go straight to the epsilon product.
                mcand_nxt  = {64'd0, item_r.attr ? 64'd0 : mres};
                mplier_nxt = {44'd0, item_r.abs_eps};
                neg_nxt    = item_r.eps_neg;
                op_nxt     = OP_EPS;
                if (item_r.attr || mres == '0 || item_r.abs_eps == '0) begin
                  e_nxt     = '0;
                  state_nxt = ST_DONE;
                end
              end else begin
                mcand_nxt  = {64'd0, s6_r};
                mplier_nxt = {48'd0, cfg.dispersion_scale};
                op_nxt     = OP_SCL;
              end
            end
            OP_SCL: begin
              if (cfg.special_mode) begin
                e_nxt = (p_spec > 64'(ljpe_pkg::E_MAX)) ? ljpe_pkg::E_MAX
                                                         : p_spec[ljpe_pkg::EnergyW-1:0];
                state_nxt = ST_DONE;
              end else begin
                mcand_nxt  = {64'd0, md};
                mplier_nxt = {44'd0, item_r.abs_eps};
                neg_nxt    = item_r.eps_neg != diff[63];
                op_nxt     = OP_EPS;
                if (md == '0 || item_r.abs_eps == '0) begin
                  e_nxt     = '0;
                  state_nxt = ST_DONE;
                end
              end
            end
            OP_EPS: begin
              state_nxt = ST_DONE;
              if (acc_r[127:62] != '0) begin
                e_nxt = neg_r ? ljpe_pkg::E_MIN : ljpe_pkg::E_MAX;
              end else if (neg_r) begin
                e_nxt = (p_eps > 48'(ljpe_pkg::E_MAX) + 48'd1) ? ljpe_pkg::E_MIN
                        : -$signed(p_eps[ljpe_pkg::EnergyW-1:0]);
              end else begin
                e_nxt = (p_eps > 48'(ljpe_pkg::E_MAX)) ? ljpe_pkg::E_MAX
                        : $signed(p_eps[ljpe_pkg::EnergyW-1:0]);
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          oe_nxt        = e_r;
          ot_nxt        = sum_sat;
          orej_nxt      = rej_r;
          odone_nxt     = item_r.last;
          total_nxt     = item_r.last ? '0 : sum_sat;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
    op_r     <= op_nxt;
    item_r   <= item_nxt;
    s_r      <= s_nxt;
    s6_r     <= s6_nxt;
    s12_r    <= s12_nxt;
    num_r    <= num_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    neg_r    <= neg_nxt;
    rej_r    <= rej_nxt;
    e_r      <= e_nxt;
    oe_r     <= oe_nxt;
    ot_r     <= ot_nxt;
    orej_r   <= orej_nxt;
    odone_r  <= odone_nxt;
  end

endmodule

>>> rtl/core/lj_pair_energy_accumulator.sv
// Lennard-Jones 12-6 pair energy with a saturating running total. The front
// classifies each pair as it is pushed (cutoff, exclusion, cavity rejection,
// cached energy) and places it in a short queue; the back pops one pair at a
// time. A computed pair goes through the bit-serial divider for s = |sigma|/r,
// then up to six shift-and-add multiplications of one multiplier bit per cycle
// (each stops early on its highest set bit). The result register lets the back
// start the next pair while a result waits to be popped.
module lj_pair_energy_accumulator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ljpe_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [ljpe_pkg::CfgDatW-1:0]         cfg_data,
  input  logic                                 push,
  output logic                                 full,
  input  logic [ljpe_pkg::DistW-1:0]           in_pair_distance,
  input  logic signed [ljpe_pkg::SigW-1:0]     in_pair_sigma,
  input  logic signed [ljpe_pkg::EpsW-1:0]     in_pair_epsilon,
  input  logic                                 in_excluded,
  input  logic                                 in_frozen_pair,
  input  logic                                 in_attr_only,
  input  logic                                 in_recalculate,
  input  logic signed [ljpe_pkg::EnergyW-1:0]  in_cached_energy,
  input  logic                                 in_last_pair,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [ljpe_pkg::EnergyW-1:0]  out_pair_energy,
  output logic signed [ljpe_pkg::TotalW-1:0]   out_total_energy,
  output logic                                 out_rejected,
  output logic                                 out_sum_done
);

  ljpe_pkg::cfg_t   cfg_r, cfg_nxt;
  ljpe_pkg::entry_t f_entry, q_data;
  logic             q_empty, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ljpe_pkg::REG_CUTOFF:   cfg_nxt.cutoff_distance  = cfg_data;
        ljpe_pkg::REG_SLACK:    cfg_nxt.cutoff_slack     = cfg_data[15:0];
        ljpe_pkg::REG_DSCALE:   cfg_nxt.dispersion_scale = cfg_data[15:0];
        ljpe_pkg::REG_REP_ONLY: cfg_nxt.repulsion_only   = cfg_data[0];
        ljpe_pkg::REG_SPECIAL:  cfg_nxt.special_mode     = cfg_data[0];
        ljpe_pkg::REG_CAV_EN:   cfg_nxt.cavity_enable    = cfg_data[0];
        ljpe_pkg::REG_CAV_SCL:  cfg_nxt.cavity_scale     = cfg_data[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff_distance  <= 24'hFF_FFFF;
      cfg_r.cutoff_slack     <= '0;
      cfg_r.dispersion_scale <= 16'd16384;
      cfg_r.repulsion_only   <= 1'b0;
      cfg_r.special_mode     <= 1'b0;
      cfg_r.cavity_enable    <= 1'b0;
      cfg_r.cavity_scale     <= 16'd16384;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ljpe_front u_front (
    .cfg             (cfg_r),
    .pair_distance   (in_pair_distance),
    .pair_sigma      (in_pair_sigma),
    .pair_epsilon    (in_pair_epsilon),
    .excluded        (in_excluded),
    .frozen_pair     (in_frozen_pair),
    .attr_only       (in_attr_only),
    .recalculate     (in_recalculate),
    .cached_energy   (in_cached_energy),
    .last_pair       (in_last_pair),
    .entry           (f_entry)
  );

  ljpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (f_entry),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  ljpe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_data           (q_data),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (empty),
    .out_pop          (pop),
    .out_pair_energy  (out_pair_energy),
    .out_total_energy (out_total_energy),
    .out_rejected     (out_rejected),
    .out_sum_done     (out_sum_done)
  );

endmodule

>>> tb/lj_pair_energy_accumulator_tb.sv
module lj_pair_energy_accumulator_tb;

  localparam longint EMAX64 = 64'sd549755813887;
  localparam longint EMIN64 = -64'sd549755813888;
  localparam longint TMAX64 = 64'sd140737488355327;
  localparam longint TMIN64 = -64'sd140737488355328;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 600;

  typedef struct {
    logic [ljpe_pkg::DistW-1:0]          distance;
    logic signed [ljpe_pkg::SigW-1:0]    sigma;
    logic signed [ljpe_pkg::EpsW-1:0]    eps;
    bit                                  excl;
    bit                                  frz;
    bit                                  attr;
    bit                                  recalc;
    logic signed [ljpe_pkg::EnergyW-1:0] cached;
    bit                                  last;
  } pair_t;

  typedef struct {
    logic signed [ljpe_pkg::EnergyW-1:0] energy;
    logic signed [ljpe_pkg::TotalW-1:0]  total;
    bit                                  rej;
    bit                                  done;
  } energy_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ljpe_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [ljpe_pkg::CfgDatW-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [ljpe_pkg::DistW-1:0] in_pair_distance = '0;
  logic signed [ljpe_pkg::SigW-1:0] in_pair_sigma = '0;
  logic signed [ljpe_pkg::EpsW-1:0] in_pair_epsilon = '0;
  logic in_excluded = 1'b0;
  logic in_frozen_pair = 1'b0;
  logic in_attr_only = 1'b0;
  logic in_recalculate = 1'b0;
  logic signed [ljpe_pkg::EnergyW-1:0] in_cached_energy = '0;
  logic in_last_pair = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [ljpe_pkg::EnergyW-1:0] out_pair_energy;
  logic signed [ljpe_pkg::TotalW-1:0] out_total_energy;
  logic out_rejected;
  logic out_sum_done;

  lj_pair_energy_accumulator DUT (.*);

  always #4 clk = ~clk;

  // Model copy of the registers and the running sum.
  longint unsigned m_cutoff, m_slack, m_dscale, m_rep_only, m_special, m_cav_en, m_cav_scl;
  longint m_total;

  pair_t pending_pairs[$];
  energy_t expected_results[$];
  int errors = 0;
  int checked = 0;
  int rejections = 0;
  int sums_closed = 0;
  int cycles = 0;
  bit hold_req = 1'b0;

  function automatic longint unsigned mul_sat(longint unsigned a, longint unsigned b,
                                              int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] != 0) return ljpe_pkg::P_MAX;
    p = p >> sh;
    if (p > ljpe_pkg::P_MAX) return ljpe_pkg::P_MAX;
    return p[63:0];
  endfunction

  function automatic longint lj_energy(longint unsigned r, longint unsigned mag,
                                       longint eps, bit attr);
    longint unsigned s, s3, s6, s12, t6, t12, md, ae, p;
    longint diff;
    bit neg;
    if (mag == 0) s = 0;
    else if (r == 0) s = ljpe_pkg::P_MAX;
    else s = (mag << 24) / r;
    s3 = mul_sat(mul_sat(s, s, 24), s, 24);
    s6 = mul_sat(s3, s3, 24);
    s12 = mul_sat(s6, s6, 24);
    if (m_special != 0) begin
      p = mul_sat(m_dscale, s12, 14) >> 8;
      return (p > longint'(EMAX64)) ? EMAX64 : longint'(p);
    end
    t6 = (m_rep_only != 0) ? 0 : mul_sat(m_dscale, s6, 14);
    t12 = attr ? 0 : s12;
    diff = longint'(t12) - longint'(t6);
    md = (diff < 0) ? -diff : diff;
    ae = (eps < 0) ? -eps : eps;
    if (md == 0 || ae == 0) return 0;
    neg = (eps < 0) != (diff < 0);
    if (md > (64'hFFFF_FFFF_FFFF_FFFF / 4) / ae) return neg ? EMIN64 : EMAX64;
    p = (md * ae * 4) >> 16;
    if (neg) return (p > longint'(EMAX64) + 1) ? EMIN64 : -longint'(p);
    return (p > longint'(EMAX64)) ? EMAX64 : longint'(p);
  endfunction

  function automatic energy_t predict_pair(pair_t it);
    energy_t res;
    longint unsigned r, mag;
    longint e, sum, sig;
    r = it.distance;
    sig = it.sigma;
    mag = (sig < 0) ? -sig : sig;
    e = 0;
    res.rej = 1'b0;
    if (!it.recalc) begin
      e = it.cached;
    end else if (longint'(r) - longint'(m_slack) < longint'(m_cutoff) && !it.excl && !it.frz) begin
      e = lj_energy(r, mag, it.eps, it.attr);
      if (m_cav_en != 0 && (r << 14) < m_cav_scl * mag) begin
        e = EMAX64;
        res.rej = 1'b1;
      end
    end
    sum = m_total + e;
    if (sum > TMAX64) sum = TMAX64;
    if (sum < TMIN64) sum = TMIN64;
    m_total = it.last ? 0 : sum;
    res.energy = e[ljpe_pkg::EnergyW-1:0];
    res.total = sum[ljpe_pkg::TotalW-1:0];
    res.done = it.last;
    return res;
  endfunction

  function automatic pair_t rand_pair(bit cheap);
    pair_t it;
    int unsigned mag;
    longint unsigned d;
    if ($urandom_range(0, 15) == 0) begin
      it.sigma = ljpe_pkg::SigW'($urandom());
    end else begin
      mag = $urandom_range(1 << 15, 6 << 16);
      it.sigma = $urandom_range(0, 1) ? -$signed({1'b0, mag[22:0]}) : $signed({1'b0, mag[22:0]});
    end
    case ($urandom_range(0, 19))
      0: it.distance = '0;
      1, 2: it.distance = ljpe_pkg::DistW'($urandom());
      default: begin
        d = (it.sigma < 0) ? -longint'(it.sigma) : longint'(it.sigma);
        d = d * $urandom_range(80, 320) / 100;
        it.distance = (d > 24'hFFFFFF) ? 24'hFFFFFF : d[23:0];
      end
    endcase
    if ($urandom_range(0, 7) == 0) it.eps = ljpe_pkg::EpsW'($urandom());
    else begin
      it.eps = ljpe_pkg::EpsW'($urandom_range(1, 200 << 8));
      if ($urandom_range(0, 3) == 0) it.eps = -it.eps;
    end
    it.excl = ($urandom_range(0, 9) == 0);
    it.frz = ($urandom_range(0, 9) == 0);
    it.attr = ($urandom_range(0, 4) == 0);
    it.recalc = cheap ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) != 0);
    it.cached = ljpe_pkg::EnergyW'({$urandom(), $urandom()});
    it.last = ($urandom_range(0, 6) == 0);
    return it;
  endfunction

  function automatic pair_t mk_pair(logic [ljpe_pkg::DistW-1:0] distance,
                                    logic signed [ljpe_pkg::SigW-1:0] sigma,
                                    logic signed [ljpe_pkg::EpsW-1:0] eps, bit excl, bit frz,
                                    bit attr, bit recalc,
                                    logic signed [ljpe_pkg::EnergyW-1:0] cached,
                                    bit last);
    pair_t it;
    it.distance = distance; it.sigma = sigma; it.eps = eps; it.excl = excl; it.frz = frz;
    it.attr = attr; it.recalc = recalc; it.cached = cached; it.last = last;
    return it;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(predict_pair(pending_pairs.pop_front()));
      end
      if (push && full) begin
        // Hold the offered item until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        in_pair_distance <= pending_pairs[0].distance;
        in_pair_sigma <= pending_pairs[0].sigma;
        in_pair_epsilon <= pending_pairs[0].eps;
        in_excluded <= pending_pairs[0].excl;
        in_frozen_pair <= pending_pairs[0].frz;
        in_attr_only <= pending_pairs[0].attr;
        in_recalculate <= pending_pairs[0].recalc;
        in_cached_energy <= pending_pairs[0].cached;
        in_last_pair <= pending_pairs[0].last;
        push <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern is redrawn at random among always, mostly and rarely
  // popping; a toggle of hold_req starts a long stretch with no pops at all.
  int hold_left = 0;
  bit hold_seen = 1'b0;
  int pop_mode = 0;
  int mode_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: energy %0d total %0d",
                 out_pair_energy, out_total_energy);
          errors++;
        end else begin
          energy_t ex;
          ex = expected_results.pop_front();
          checked++;
          if (out_pair_energy !== ex.energy) begin
            $error("pair_energy expected %0d actual %0d", ex.energy, out_pair_energy);
            errors++;
          end
          if (out_total_energy !== ex.total) begin
            $error("total_energy expected %0d actual %0d", ex.total, out_total_energy);
            errors++;
          end
          if (out_rejected !== ex.rej) begin
            $error("rejected expected %0d actual %0d", ex.rej, out_rejected);
            errors++;
          end
          if (out_sum_done !== ex.done) begin
            $error("sum_done expected %0d actual %0d", ex.done, out_sum_done);
            errors++;
          end
          if (ex.rej) rejections++;
          if (ex.done) sums_closed++;
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 600;
      end
      mode_cnt++;
      if (mode_cnt == 128) begin
        mode_cnt = 0;
        pop_mode = $urandom_range(0, 2);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_mode == 0) pop <= 1'b1;
      else if (pop_mode == 1) pop <= ($urandom_range(0, 3) != 0);
      else pop <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_pairs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    // Leave a quiet stretch before the next configuration.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [ljpe_pkg::CfgIdxW-1:0] idx, longint unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[ljpe_pkg::CfgDatW-1:0];
    case (idx)
      ljpe_pkg::REG_CUTOFF:   m_cutoff = val & 64'hFFFFFF;
      ljpe_pkg::REG_SLACK:    m_slack = val & 64'hFFFF;
      ljpe_pkg::REG_DSCALE:   m_dscale = val & 64'hFFFF;
      ljpe_pkg::REG_REP_ONLY: m_rep_only = val & 1;
      ljpe_pkg::REG_SPECIAL:  m_special = val & 1;
      ljpe_pkg::REG_CAV_EN:   m_cav_en = val & 1;
      ljpe_pkg::REG_CAV_SCL:  m_cav_scl = val & 64'hFFFF;
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_random(int n, bit cheap);
    repeat (n) pending_pairs.push_back(rand_pair(cheap));
  endtask

  initial begin
    pair_t it;
    m_cutoff = 24'hFFFFFF; m_slack = 0; m_dscale = 16384; m_rep_only = 0;
    m_special = 0; m_cav_en = 0; m_cav_scl = 16384; m_total = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs under the reset settings.
    pending_pairs.push_back(mk_pair(24'h030000, 24'sh030000, 20'sh07800, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h048000, -24'sh030000, 20'sh07FFFF, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h040000, 24'sh030000, -20'sh80000, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h040000, 24'sh030000, 20'sh00000, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h040000, 24'sh000000, 20'sh01000, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h000000, 24'sh030000, 20'sh01000, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h000000, -24'sh800000, -20'sh01000, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'hFFFFFF, 24'sh7FFFFF, 20'sh01000, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'hFFFFFE, 24'sh7FFFFF, 20'sh7FFFF, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h000001, 24'sh000001, 20'sh01000, 0, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h030000, 24'sh030000, 20'sh01000, 1, 0, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h030000, 24'sh030000, 20'sh01000, 0, 1, 0, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h030000, 24'sh030000, 20'sh01000, 0, 0, 1, 1, '0, 0));
    pending_pairs.push_back(mk_pair(24'h030000, 24'sh030000, 20'sh01000, 0, 0, 0, 0,
                                    40'sh7F_FFFF_FFFF, 0));
    pending_pairs.push_back(mk_pair(24'h030000, 24'sh030000, 20'sh01000, 0, 0, 0, 0,
                                    40'sh80_0000_0000, 1));
    pending_pairs.push_back(mk_pair(24'h030000, 24'sh030000, 20'sh01000, 0, 0, 0, 0,
                                    40'sh00_0000_1234, 1));
    wait_idle();

    // Tight cutoff with slack, full dispersion scale, cavity rejection on.
    cfg_write(ljpe_pkg::REG_CUTOFF, 24'h038000);
    cfg_write(ljpe_pkg::REG_SLACK, 16'h8000);
    cfg_write(ljpe_pkg::REG_DSCALE, 16'hFFFF);
    cfg_write(ljpe_pkg::REG_CAV_EN, 1);
    cfg_write(ljpe_pkg::REG_CAV_SCL, 16'h3400);
    cfg_done();
    pending_pairs.push_back(mk_pair(24'h02C000, 24'sh030000, 20'sh01000, 0, 0, 0, 1, '0, 0));
    add_random(40, 0);
    wait_idle();

    // Repulsion only, zero scale, cutoff closed except through the slack.
    cfg_write(ljpe_pkg::REG_CUTOFF, 0);
    cfg_write(ljpe_pkg::REG_SLACK, 16'hFFFF);
    cfg_write(ljpe_pkg::REG_DSCALE, 0);
    cfg_write(ljpe_pkg::REG_REP_ONLY, 1);
    cfg_write(ljpe_pkg::REG_CAV_EN, 0);
    cfg_write(3'd7, 24'hFFFFFF);
    cfg_done();
    add_random(40, 0);
    wait_idle();

    // Special mode with the largest scales, cavity rejection at its widest.
    cfg_write(ljpe_pkg::REG_CUTOFF, 24'hFFFFFF);
    cfg_write(ljpe_pkg::REG_SLACK, 0);
    cfg_write(ljpe_pkg::REG_DSCALE, 16'hFFFF);
    cfg_write(ljpe_pkg::REG_SPECIAL, 1);
    cfg_write(ljpe_pkg::REG_CAV_EN, 1);
    cfg_write(ljpe_pkg::REG_CAV_SCL, 16'hFFFF);
    cfg_done();
    add_random(40, 0);
    wait_idle();

    // Normal mode again with a moderate cutoff.
    cfg_write(ljpe_pkg::REG_SPECIAL, 0);
    cfg_write(ljpe_pkg::REG_REP_ONLY, 0);
    cfg_write(ljpe_pkg::REG_DSCALE, 16'h2000);
    cfg_write(ljpe_pkg::REG_CUTOFF, 24'h0A0000);
    cfg_write(ljpe_pkg::REG_CAV_SCL, 16'h2C00);
    cfg_done();
    add_random(40, 0);
    wait_idle();

    // Mostly cached energies at the extremes, with a long stall on the
    // receiving side so the queue fills; the total runs into saturation.
    cfg_write(ljpe_pkg::REG_CAV_EN, 0);
    cfg_done();
    hold_req <= 1'b1;
    repeat (270) begin
      it = rand_pair(1);
      it.recalc = 0; it.last = 0; it.cached = 40'sh7F_FFFF_FFFF;
      pending_pairs.push_back(it);
    end
    repeat (8) begin
      it = rand_pair(1);
      it.recalc = 0; it.last = 0; it.cached = 40'sh80_0000_0000;
      pending_pairs.push_back(it);
    end
    add_random(15, 1);
    it.last = 1;
    pending_pairs.push_back(it);
    wait_idle();

    $display("checked %0d results: %0d cavity rejections, %0d sums closed",
             checked, rejections, sums_closed);
    $display("settings covered cutoff/slack, dispersion scale, repulsion-only, special mode");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ljpe_pkg.sv
rtl/core/ljpe_front.sv
rtl/core/ljpe_queue.sv
rtl/core/ljpe_back.sv
rtl/core/lj_pair_energy_accumulator.sv
tb/lj_pair_energy_accumulator_tb.sv
